### rtl/ipc_pkg.sv
// Shared constants and types for the IP address text classifier.
`timescale 1ns / 1ps

package ipc_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned V4_CNT_W = 3;
  localparam int unsigned V4_VALUE_W = 10;
  localparam int unsigned V6_GROUP_W = 4;
  localparam int unsigned V6_DIGIT_W = 3;

  localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;

  localparam logic [V4_CNT_W-1:0] V4_MAX_DIGITS = 3'd3;
  localparam logic [V4_CNT_W-1:0] V4_LAST_GROUP = 3'd3;
  localparam logic [V4_CNT_W-1:0] V4_CNT_SAT = 3'd7;
  localparam logic [V4_VALUE_W-1:0] V4_MAX_VALUE = 10'd255;
  localparam logic [V6_DIGIT_W-1:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [V6_DIGIT_W-1:0] V6_DIGIT_SAT = 3'd7;
  localparam logic [V6_GROUP_W-1:0] V6_LAST_GROUP = 4'd7;
  localparam logic [V6_GROUP_W-1:0] V6_GROUP_SAT = 4'd15;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_V4   = 2'd1,
    VERDICT_V6   = 2'd2
  } verdict_t;

endpackage

### rtl/ipc_scan.sv
// Per-character scanner: both address validators and the end-of-string verdict.
`timescale 1ns / 1ps

module ipc_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic [ipc_pkg::CHAR_W-1:0]       char_code,
  input  logic                             last_char,
  output ipc_pkg::verdict_t                verdict_next
);

  typedef struct packed {
    logic                                seen_dot;
    logic                                seen_colon;
    logic [ipc_pkg::V4_CNT_W-1:0]        v4_group_count;
    logic [ipc_pkg::V4_CNT_W-1:0]        v4_digit_count;
    logic [ipc_pkg::V4_VALUE_W-1:0]      v4_group_value;
    logic                                v4_leading_zero;
    logic                                v4_failed;
    logic [ipc_pkg::V6_GROUP_W-1:0]      v6_group_count;
    logic [ipc_pkg::V6_DIGIT_W-1:0]      v6_digit_count;
    logic                                v6_failed;
  } scan_state_t;

  scan_state_t scan;
  scan_state_t scan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (take) begin
      scan <= scan_next;
    end
  end

  always_comb begin
    scan_state_t                       s;
    logic                              is_dot;
    logic                              is_colon;
    logic                              is_dec;
    logic                              is_hex;
    logic [ipc_pkg::V4_VALUE_W+3:0]    grown;

    s = scan;
    is_dot = (char_code == ipc_pkg::CHAR_DOT);
    is_colon = (char_code == ipc_pkg::CHAR_COLON);
    is_dec = (char_code >= ipc_pkg::CHAR_ZERO) && (char_code <= ipc_pkg::CHAR_NINE);
    is_hex = is_dec
      || ((char_code >= ipc_pkg::CHAR_LOWER_A) && (char_code <= ipc_pkg::CHAR_LOWER_F))
      || ((char_code >= ipc_pkg::CHAR_UPPER_A) && (char_code <= ipc_pkg::CHAR_UPPER_F));
    grown = ({4'b0, s.v4_group_value} << 3) + ({4'b0, s.v4_group_value} << 1)
      + {10'b0, char_code[3:0]};
    verdict_next = ipc_pkg::VERDICT_NONE;

    if (is_dot) begin
      s.seen_dot = 1'b1;
    end
    if (is_colon) begin
      s.seen_colon = 1'b1;
    end

    if (is_dec) begin
      if (s.v4_digit_count == '0) begin
        s.v4_leading_zero = (char_code == ipc_pkg::CHAR_ZERO);
      end else if (s.v4_leading_zero) begin
        s.v4_failed = 1'b1;
      end
      if (s.v4_digit_count < ipc_pkg::V4_MAX_DIGITS) begin
        s.v4_group_value = grown[ipc_pkg::V4_VALUE_W-1:0];
      end else begin
        s.v4_failed = 1'b1;
      end
      if (s.v4_digit_count < ipc_pkg::V4_CNT_SAT) begin
        s.v4_digit_count = s.v4_digit_count + 1'b1;
      end
    end else if (is_dot) begin
      if ((s.v4_digit_count == '0) || (s.v4_group_value > ipc_pkg::V4_MAX_VALUE)) begin
        s.v4_failed = 1'b1;
      end
      if (s.v4_group_count < ipc_pkg::V4_CNT_SAT) begin
        s.v4_group_count = s.v4_group_count + 1'b1;
      end
      s.v4_digit_count = '0;
      s.v4_group_value = '0;
      s.v4_leading_zero = 1'b0;
    end else begin
      s.v4_failed = 1'b1;
    end

    if (is_hex) begin
      if (s.v6_digit_count >= ipc_pkg::V6_MAX_DIGITS) begin
        s.v6_failed = 1'b1;
      end
      if (s.v6_digit_count < ipc_pkg::V6_DIGIT_SAT) begin
        s.v6_digit_count = s.v6_digit_count + 1'b1;
      end
    end else if (is_colon) begin
      if (s.v6_digit_count == '0) begin
        s.v6_failed = 1'b1;
      end
      if (s.v6_group_count < ipc_pkg::V6_GROUP_SAT) begin
        s.v6_group_count = s.v6_group_count + 1'b1;
      end
      s.v6_digit_count = '0;
    end else begin
      s.v6_failed = 1'b1;
    end

    if (last_char) begin
      if (s.seen_dot) begin
        if ((s.v4_digit_count == '0) || (s.v4_group_value > ipc_pkg::V4_MAX_VALUE)) begin
          s.v4_failed = 1'b1;
        end
        if (!s.v4_failed && (s.v4_group_count == ipc_pkg::V4_LAST_GROUP)) begin
          verdict_next = ipc_pkg::VERDICT_V4;
        end
      end else if (s.seen_colon) begin
        if (s.v6_digit_count == '0) begin
          s.v6_failed = 1'b1;
        end
        if (!s.v6_failed && (s.v6_group_count == ipc_pkg::V6_LAST_GROUP)) begin
          verdict_next = ipc_pkg::VERDICT_V6;
        end
      end
      scan_next = '0;
    end else begin
      scan_next = s;
    end
  end

endmodule

### rtl/ip_address_text_classifier.sv
// Top level of the IP address text classifier: handshakes and result register.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------
//   item     | item_valid / item_stall  | char_code, last_char
//   result   | result_valid/result_stall| verdict
//
// One character beat is taken per cycle unless item_stall is high; the scanner
// updates its state in that same cycle. The verdict appears in the cycle after
// the last_char beat, from the result register. Reset clears the scanner and
// result_valid. item_stall rises only while a verdict waits and is stalled.
`timescale 1ns / 1ps

module ip_address_text_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [ipc_pkg::CHAR_W-1:0] char_code,
  input  logic                       last_char,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [1:0]                 verdict
);

  logic              take;
  ipc_pkg::verdict_t verdict_next;

  assign item_stall = result_valid && result_stall;
  assign take = item_valid && !item_stall;

  ipc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .char_code    (char_code),
    .last_char    (last_char),
    .verdict_next (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && last_char) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_char) begin
      verdict <= verdict_next;
    end
  end

endmodule
